>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Holds the stored pair type and the operation codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DATA_W = 32;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // one stored pair
   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // what a cell hands to its right-hand neighbor
   typedef struct packed {
      entry_type entry;
      logic      keep;
   } link_type;

endpackage

>>> rtl/core/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted-array priority queue, chain of cells
// Result: the result beat is offered in the cycle after the request beat is taken.
// Throughput: one item per cycle while the result side does not stall;
//   a waiting result holds off new requests (the state is shown directly).
// Reset: synchronous, active high; clears the count and the result valid.
//   Slot contents are not cleared; only occupied slots are ever shown.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic signed [spq_pkg::DATA_W-1:0] req_item_value,
   input  logic signed [spq_pkg::DATA_W-1:0] req_item_priority,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [CNT_W-1:0]                rsp_entry_count,
   output logic                            rsp_queue_empty,
   output logic                            rsp_queue_full,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_head_value,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_head_priority,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_tail_value,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_tail_priority
);
   import spq_pkg::*;

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accepted_ff, accepted_in;

   logic req_fire;
   logic is_full, none_stored;
   logic do_insert, do_delete;

   entry_type new_entry;
   link_type  links [QUEUE_DEPTH+1];
   entry_type tail_entry;

   assign is_full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign none_stored = (count_ff == '0);

   // a new request may land in the same cycle the pending result leaves
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   // full insert and empty delete are dropped, reported as not accepted
   assign do_insert = req_fire && (req_operation == OP_INSERT) && !is_full;
   assign do_delete = req_fire && (req_operation == OP_DELETE) && !none_stored;

   assign new_entry.data = req_item_value;
   assign new_entry.prio = req_item_priority;

   // left end of the chain: cell 0 takes the new pair unless it keeps its own
   assign links[0].entry = new_entry;
   assign links[0].keep  = 1'b1;

   // the chain; delete needs no data movement, the count simply drops
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic occupied;
      assign occupied = (CNT_W'(i) < count_ff);

      spq_cell u_cell (
         .clock     (clock),
         .shift_en  (do_insert),
         .occupied  (occupied),
         .new_entry (new_entry),
         .left_link (links[i]),
         .link_out  (links[i+1])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      accepted_in  = accepted_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         accepted_in  = do_insert || do_delete;
         priority if (do_insert) begin
            count_in = count_ff + CNT_W'(1);
         end else if (do_delete) begin
            count_in = count_ff - CNT_W'(1);
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      accepted_ff <= accepted_in;
   end

   // tail pick: each cell compares its index against the count, AND-OR mux
   always_comb begin
      tail_entry = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (count_ff == CNT_W'(i + 1)) begin
            tail_entry = tail_entry | links[i+1].entry;
         end
      end
   end

   // result beat: state is frozen while the beat waits, so it reads live
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_queue_empty   = none_stored;
   assign rsp_queue_full    = is_full;
   assign rsp_head_value    = none_stored ? '0 : links[1].entry.data;
   assign rsp_head_priority = none_stored ? '0 : links[1].entry.prio;
   assign rsp_tail_value    = tail_entry.data;
   assign rsp_tail_priority = tail_entry.prio;

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)) && accepted_ff)
      else $error("insert did not grow the queue");

   a_delete_shrinks : assert property (@(posedge clock) disable iff (reset)
      do_delete |=> (count_ff == $past(count_ff) - CNT_W'(1)) && accepted_ff)
      else $error("delete did not shrink the queue");

   a_sorted : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !none_stored) |-> (rsp_head_priority >= rsp_tail_priority))
      else $error("head priority below tail priority");

   a_hold_while_waiting : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(count_ff) && rsp_valid_ff)
      else $error("queue state moved while a result beat waited");
`endif

endmodule

>>> rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds a pair; on insert it keeps it, takes the new pair or takes its
// left neighbor's pair, depending on its own compare and the neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  logic               occupied,
   input  spq_pkg::entry_type new_entry,
   input  spq_pkg::link_type  left_link,
   output spq_pkg::link_type  link_out
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      keep;

   // a stored pair of greater or equal priority stays ahead of the new one
   assign keep = occupied && (entry_ff.prio >= new_entry.prio);

   always_comb begin
      priority if (!shift_en || keep) begin
         entry_in = entry_ff;
      end else if (left_link.keep) begin
         entry_in = new_entry;
      end else begin
         entry_in = left_link.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link_out.entry = entry_ff;
   assign link_out.keep  = keep;

endmodule
